// ===== hdl/sorted_list_engine_defines.svh =====
// assertion macros shared by the sorted list engine
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH

// checked while out of reset
`define SLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sle_pkg.sv =====
package sle_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_DELETE = 3'd1;
    localparam logic [2:0] FUNC_FIND   = 3'd2;
    localparam logic [2:0] FUNC_RESET  = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ABSENT   = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;
    localparam logic [1:0] STATUS_PAST_END = 2'd3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    // per-beat command broadcast to every cell
    typedef struct packed {
        logic             ins_en;
        logic             del_en;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic [CNT_W-1:0] count;
        data_t            value;
    } cell_cmd_t;

    // left-to-right link between neighbouring cells
    typedef struct packed {
        logic  lt;
        logic  eq_seen;
        data_t rd;
        data_t val;
    } cell_link_t;

endpackage

// ===== hdl/sle_if.sv =====
interface sle_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        func;
    sle_pkg::data_t    value_in;

    modport source (output valid, output func, output value_in, input ready);
    modport sink   (input valid, input func, input value_in, output ready);
endinterface

interface sle_rsp_if;
    logic                        valid;
    logic                        ready;
    sle_pkg::data_t              value_out;
    logic                        found;
    logic [sle_pkg::CNT_W-1:0]   count;
    logic                        full_res;
    logic [1:0]                  status;

    modport source (output valid, output value_out, output found, output count,
                    output full_res, output status, input ready);
    modport sink   (input valid, input value_out, input found, input count,
                    input full_res, input status, output ready);
endinterface

// ===== hdl/sle_cell.sv =====
module sle_cell
(
    input  logic                      clk,
    input  logic [sle_pkg::IDX_W-1:0] index,
    input  sle_pkg::cell_cmd_t        cmd,
    input  sle_pkg::cell_link_t       left,
    output sle_pkg::cell_link_t       right,
    input  sle_pkg::data_t            right_value,
    output sle_pkg::data_t            value
);

    sle_pkg::data_t value_reg;
    sle_pkg::data_t value_next;
    logic           occupied;
    logic           lt_here;
    logic           eq_here;
    logic           rd_sel;

    assign occupied = sle_pkg::CNT_W'(index) < cmd.count;
    assign lt_here  = occupied && (value_reg < cmd.value);
    assign eq_here  = occupied && (value_reg == cmd.value);
    assign rd_sel   = cmd.rd_en && (index == cmd.rd_idx);

    assign right.lt      = lt_here;
    assign right.eq_seen = left.eq_seen || eq_here;
    assign right.rd      = left.rd | (rd_sel ? value_reg : '0);
    assign right.val     = value_reg;
    assign value         = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins_en)
        begin
            if (!lt_here)
            begin
                value_next = left.lt ? cmd.value : left.val;
            end
        end
        else if (cmd.del_en && (left.eq_seen || eq_here))
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== hdl/sorted_list_engine.sv =====
// sorted list engine
// keeps up to sle_pkg::CAPACITY signed values in ascending order in a row of
// cells, one value per cell
// req channel: one beat per operation (func, value_in); func selects insert,
// delete, find, cursor reset or read next
// rsp channel: exactly one beat per request, in request order, carrying the
// value read, the found flag, the count, the full flag and a status code
// every cell compares its value with the operand at once and the row shifts
// by one place in the same cycle, so an operation completes in the cycle it
// is taken; that single compare-and-shift through the cell row sets the rate
// the response is registered and is valid in the cycle after acceptance
// throughput: one beat per cycle while the receiver takes responses
// when the receiver stalls, the response register holds its beat and a new
// request is taken only in a cycle where that beat leaves
// reset empties the list and parks the cursor before the first value; the
// stored values themselves are not cleared
module sorted_list_engine
(
    input  logic           clk,
    input  logic           rst_n,
    sle_req_if.sink        req,
    sle_rsp_if.source      rsp
);

`include "sorted_list_engine_defines.svh"

    localparam int CAP = sle_pkg::CAPACITY;
    localparam int IW  = sle_pkg::IDX_W;
    localparam int CW  = sle_pkg::CNT_W;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [IW-1:0]       cursor_reg;
    logic [IW-1:0]       cursor_next;
    logic                started_reg;
    logic                started_next;
    logic                rsp_valid_reg;

    sle_pkg::data_t      value_out_reg;
    logic                found_reg;
    logic [CW-1:0]       rsp_count_reg;
    logic                full_res_reg;
    logic [1:0]          status_reg;

    logic                fire;
    logic                full;
    logic [CW-1:0]       rd_pos;
    logic                past_end;
    logic                eq_any;
    logic [1:0]          status;
    sle_pkg::data_t      value_out;
    logic                found;

    sle_pkg::cell_cmd_t  cmd;
    sle_pkg::cell_link_t link [CAP+1];
    sle_pkg::data_t      back [CAP+1];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;
    assign full      = count_reg == CW'(CAP);
    assign rd_pos    = started_reg ? (CW'(cursor_reg) + CW'(1)) : '0;
    assign past_end  = rd_pos >= count_reg;
    assign eq_any    = link[CAP].eq_seen;

    assign cmd.ins_en = fire && (req.func == sle_pkg::FUNC_INSERT) && !full;
    assign cmd.del_en = fire && (req.func == sle_pkg::FUNC_DELETE) && eq_any;
    assign cmd.rd_en  = (req.func == sle_pkg::FUNC_READ) && !past_end;
    assign cmd.rd_idx = rd_pos[IW-1:0];
    assign cmd.count  = count_reg;
    assign cmd.value  = req.value_in;

    // head of the row: an insert lands in cell 0 unless it holds a smaller value
    assign link[0].lt      = 1'b1;
    assign link[0].eq_seen = 1'b0;
    assign link[0].rd      = '0;
    assign link[0].val     = '0;
    assign back[CAP]       = '0;

    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        sle_cell u_cell
        (
            .clk         (clk),
            .index       (IW'(i)),
            .cmd         (cmd),
            .left        (link[i]),
            .right       (link[i+1]),
            .right_value (back[i+1]),
            .value       (back[i])
        );
    end

    always_comb
    begin
        status       = sle_pkg::STATUS_OK;
        value_out    = '0;
        found        = 1'b0;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        started_next = started_reg;
        unique case (req.func)
            sle_pkg::FUNC_INSERT:
            begin
                if (full)
                begin
                    status = sle_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            sle_pkg::FUNC_DELETE:
            begin
                found = eq_any;
                if (eq_any)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status = sle_pkg::STATUS_ABSENT;
                end
            end
            sle_pkg::FUNC_FIND:
            begin
                found = eq_any;
            end
            sle_pkg::FUNC_RESET:
            begin
                cursor_next  = '0;
                started_next = 1'b0;
            end
            sle_pkg::FUNC_READ:
            begin
                if (past_end)
                begin
                    status = sle_pkg::STATUS_PAST_END;
                end
                else
                begin
                    value_out    = link[CAP].rd;
                    cursor_next  = rd_pos[IW-1:0];
                    started_next = 1'b1;
                end
            end
            default:
            begin
                status = sle_pkg::STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            started_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                cursor_reg    <= cursor_next;
                started_reg   <= started_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            value_out_reg <= value_out;
            found_reg     <= found;
            rsp_count_reg <= count_next;
            full_res_reg  <= count_next == CW'(CAP);
            status_reg    <= status;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.value_out = value_out_reg;
    assign rsp.found     = found_reg;
    assign rsp.count     = rsp_count_reg;
    assign rsp.full_res  = full_res_reg;
    assign rsp.status    = status_reg;

    `SLE_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAP), "count above capacity")
    `SLE_ASSERT(a_insert_grows, cmd.ins_en |=> count_reg == $past(count_reg) + CW'(1), "insert did not grow count")
    `SLE_ASSERT(a_found_ok, rsp_valid_reg && found_reg |-> status_reg == sle_pkg::STATUS_OK, "found with error status")
    `SLE_ASSERT_ALWAYS(a_cursor_park, !started_reg |-> cursor_reg == '0, "cursor moved while not started")

endmodule
